// ===== rtl/bia_pkg.sv =====
// Shared types and constants for the bitmap ID allocator.
package bia_pkg;

    localparam int unsigned MAX_IDS    = 1024;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned NWORDS     = MAX_IDS / WORD_BITS;
    localparam int unsigned WORD_IDX_W = $clog2(NWORDS);
    localparam int unsigned BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int unsigned ID_W       = WORD_IDX_W + BIT_IDX_W;
    localparam int unsigned CAP_W      = ID_W + 1;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-3:0] REG_ID_LIMIT = '0;
    localparam logic [CAP_W-1:0]      CAP_RESET    = CAP_W'(MAX_IDS);
    localparam logic [CAP_W-1:0]      CAP_MAX      = CAP_W'(MAX_IDS);

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_ALLOCATED    = 2'd0,
        ST_NONE_FREE    = 2'd1,
        ST_FREED        = 2'd2,
        ST_OUT_OF_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_command        command;
        logic [ID_W-1:0] free_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        t_status         status;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FREE_WR,
        S_SCAN,
        S_HOLD
    } t_state;

    typedef enum logic [0:0] {
        RD_START,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_SET
    } t_wr_op;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        t_wr_op  wr_op;
        logic    res_load;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic fid_ok;
        logic word_full;
        logic word_last;
        logic alloc_ok;
    } t_dp_sts;

endpackage

// ===== rtl/bitmap_id_allocator.sv =====
// Top level of the bitmap ID allocator: configuration port and unit wiring.
//
// Hands out the lowest free ID below the configured ID limit (saturated to
// 1024) and releases IDs on request; each request gives exactly one result.
// The used bitmap is 32 words of 32 bits in a single-port memory read one word
// per cycle. An allocate reads the words from word 0 up to the first word with a
// clear bit; a free reads the word that holds its ID and clears the bit, unless
// the ID is out of range. Per-word written
// flags clear the bitmap at reset, so no clearing pass is needed and the
// block accepts requests in the first cycle after reset. A result waits in
// the output register while the next request is already in progress.
module bitmap_id_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  bia_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output bia_pkg::t_out_item                 o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bia_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [bia_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bia_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [bia_pkg::CAP_W-1:0] r_cap;
    logic [bia_pkg::CAP_W-1:0] eff_cap;
    logic                      reg_sel;
    bia_pkg::t_dp_cmd          dp_cmd;
    bia_pkg::t_dp_sts          dp_sts;

    assign pready  = 1'b1;
    assign reg_sel = paddr[bia_pkg::APB_ADDR_W-1:2] == bia_pkg::REG_ID_LIMIT;

    // Capacity register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bia_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_cap <= pwdata[bia_pkg::CAP_W-1:0];
        end
    end

    // Register read back
    assign prdata = reg_sel ? bia_pkg::APB_DATA_W'(r_cap) : '0;

    // Saturate capacity to the bitmap size
    assign eff_cap = (r_cap > bia_pkg::CAP_MAX) ? bia_pkg::CAP_MAX : r_cap;

    bia_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_data.command),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_sts        (dp_sts),
        .o_cmd        (dp_cmd)
    );

    bia_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cap      (eff_cap),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_data (o_out_data)
    );

endmodule

// ===== rtl/bia_dp.sv =====
// Datapath: bitmap word memory, word scan, bit set/clear and result registers.
module bia_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bia_pkg::t_in_item     i_in_data,
    input  logic [bia_pkg::CAP_W-1:0] i_cap,
    input  bia_pkg::t_dp_cmd      i_cmd,
    output bia_pkg::t_dp_sts      o_sts,
    output bia_pkg::t_out_item    o_out_data
);

    logic [bia_pkg::WORD_BITS-1:0]  mem [bia_pkg::NWORDS];
    logic [bia_pkg::NWORDS-1:0]     r_word_vld;

    logic [bia_pkg::WORD_BITS-1:0]  r_rdata;
    logic                           r_rvalid;
    logic [bia_pkg::WORD_IDX_W-1:0] r_word_idx;
    logic [bia_pkg::ID_W-1:0]       r_fid;
    bia_pkg::t_out_item             r_res;
    bia_pkg::t_out_item             r_out;

    logic [bia_pkg::WORD_IDX_W-1:0] rd_addr;
    logic [bia_pkg::WORD_BITS-1:0]  cur_word;
    logic [bia_pkg::BIT_IDX_W-1:0]  free_bit;
    logic [bia_pkg::ID_W-1:0]       alloc_id;
    logic [bia_pkg::BIT_IDX_W-1:0]  wr_bit;
    logic [bia_pkg::WORD_BITS-1:0]  bit_mask;
    logic [bia_pkg::WORD_BITS-1:0]  wr_word;

    // Pick the word to read: start word of a new request or the next in the scan
    always_comb begin
        rd_addr = r_word_idx + bia_pkg::WORD_IDX_W'(1);
        if (i_cmd.rd_sel == bia_pkg::RD_START) begin
            if (i_in_data.command == bia_pkg::CMD_FREE) begin
                rd_addr = i_in_data.free_id[bia_pkg::ID_W-1 -: bia_pkg::WORD_IDX_W];
            end else begin
                rd_addr = '0;
            end
        end
    end

    // Words never written since reset read as all free
    assign cur_word = r_rvalid ? r_rdata : '0;

    // Find the lowest clear bit of the current word
    always_comb begin
        free_bit = '0;
        for (int i = bia_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (!cur_word[i]) begin
                free_bit = bia_pkg::BIT_IDX_W'(i);
            end
        end
    end

    assign alloc_id = {r_word_idx, free_bit};

    // Build the updated word for a set or clear
    assign wr_bit   = (i_cmd.wr_op == bia_pkg::WR_SET) ? free_bit
                                                       : r_fid[bia_pkg::BIT_IDX_W-1:0];
    assign bit_mask = bia_pkg::WORD_BITS'(1) << wr_bit;
    assign wr_word  = (i_cmd.wr_op == bia_pkg::WR_SET) ? (cur_word | bit_mask)
                                                       : (cur_word & ~bit_mask);

    // Status back to the controller
    assign o_sts.fid_ok    = {1'b0, i_in_data.free_id} < i_cap;
    assign o_sts.word_full = &cur_word;
    assign o_sts.word_last = r_word_idx == bia_pkg::WORD_IDX_W'(bia_pkg::NWORDS - 1);
    assign o_sts.alloc_ok  = !(&cur_word) && ({1'b0, alloc_id} < i_cap);

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_op != bia_pkg::WR_NONE) begin
            mem[r_word_idx] <= wr_word;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Per-word written flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_rvalid   <= 1'b0;
        end else begin
            if (i_cmd.wr_op != bia_pkg::WR_NONE) begin
                r_word_vld[r_word_idx] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rvalid <= r_word_vld[rd_addr];
            end
        end
    end

    // Latch the request and track the word under test
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fid <= i_in_data.free_id;
        end
        if (i_cmd.rd_en) begin
            r_word_idx <= rd_addr;
        end
    end

    // Hold the result, then move it to the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res.status    <= i_cmd.res_status;
            r_res.result_id <= (i_cmd.res_status == bia_pkg::ST_ALLOCATED) ? alloc_id : '0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/bia_ctrl.sv =====
// Controller: request sequencing state machine and output valid.
module bia_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  bia_pkg::t_command i_in_command,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bia_pkg::t_dp_sts  i_sts,
    output bia_pkg::t_dp_cmd  o_cmd
);

    bia_pkg::t_state r_state;
    bia_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bia_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.rd_sel     = bia_pkg::RD_START;
        o_cmd.wr_op      = bia_pkg::WR_NONE;
        o_cmd.res_status = bia_pkg::ST_ALLOCATED;

        unique case (r_state)
            bia_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load  = 1'b1;
                    o_cmd.rd_en = 1'b1;
                    if (i_in_command == bia_pkg::CMD_FREE) begin
                        if (i_sts.fid_ok) begin
                            n_state = bia_pkg::S_FREE_WR;
                        end else begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = bia_pkg::ST_OUT_OF_RANGE;
                            n_state          = bia_pkg::S_HOLD;
                        end
                    end else begin
                        n_state = bia_pkg::S_SCAN;
                    end
                end
            end
            bia_pkg::S_FREE_WR: begin
                o_cmd.wr_op      = bia_pkg::WR_CLEAR;
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = bia_pkg::ST_FREED;
                n_state          = bia_pkg::S_HOLD;
            end
            bia_pkg::S_SCAN: begin
                if (!i_sts.word_full) begin
                    o_cmd.res_load = 1'b1;
                    if (i_sts.alloc_ok) begin
                        o_cmd.wr_op      = bia_pkg::WR_SET;
                        o_cmd.res_status = bia_pkg::ST_ALLOCATED;
                    end else begin
                        o_cmd.res_status = bia_pkg::ST_NONE_FREE;
                    end
                    n_state = bia_pkg::S_HOLD;
                end else if (i_sts.word_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = bia_pkg::ST_NONE_FREE;
                    n_state          = bia_pkg::S_HOLD;
                end else begin
                    // advance to the next word
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = bia_pkg::RD_NEXT;
                end
            end
            bia_pkg::S_HOLD: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bia_pkg::S_IDLE;
            end
        endcase
    end

    // Set valid on a new result, drop it once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_stall  = r_state != bia_pkg::S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

// ===== test/testbench.sv =====
// Testbench for bitmap_id_allocator: queued requests, in-order result checks against a bitmap model.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned IDLE_LIMIT    = 3000;
    localparam int unsigned SETTLE_CYCLES = 40;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    bia_pkg::t_in_item              i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    bia_pkg::t_out_item             o_out_data;
    logic                           psel        = 1'b0;
    logic                           penable     = 1'b0;
    logic                           pwrite      = 1'b0;
    logic [bia_pkg::APB_ADDR_W-1:0] paddr       = '0;
    logic [bia_pkg::APB_DATA_W-1:0] pwdata      = '0;
    logic [bia_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Model state: used bitmap and the saturated capacity
    logic [bia_pkg::WORD_BITS-1:0] used_words [bia_pkg::NWORDS] = '{default: '0};
    int unsigned                   cap_limit = bia_pkg::MAX_IDS;

    bia_pkg::t_in_item  pending_requests [$];
    bia_pkg::t_out_item expected_results [$];
    bia_pkg::t_out_item oldest_result;
    logic               in_fire = 1'b0;
    int unsigned        mismatch_count = 0;
    int unsigned        idle_cycles = 0;
    int unsigned        gap_left = 0;
    int unsigned        stall_left = 0;
    bit                 steady_in = 1'b0;
    bit                 steady_out = 1'b0;

    bitmap_id_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Apply one request to the model bitmap and return the result it gives
    function automatic bia_pkg::t_out_item apply_request(bia_pkg::t_in_item req);
        bia_pkg::t_out_item res;
        int unsigned        w;
        int unsigned        id;
        res.result_id = '0;
        if (req.command == bia_pkg::CMD_FREE) begin
            if (req.free_id < cap_limit) begin
                used_words[req.free_id / bia_pkg::WORD_BITS]
                          [req.free_id % bia_pkg::WORD_BITS] = 1'b0;
                res.status = bia_pkg::ST_FREED;
            end else begin
                res.status = bia_pkg::ST_OUT_OF_RANGE;
            end
            return res;
        end
        // skip full words, then walk bits up to the capacity
        w = 0;
        while (w < bia_pkg::NWORDS && (&used_words[w]))
            w++;
        id = w * bia_pkg::WORD_BITS;
        while (id < cap_limit
               && used_words[id / bia_pkg::WORD_BITS][id % bia_pkg::WORD_BITS])
            id++;
        if (id >= cap_limit) begin
            res.status = bia_pkg::ST_NONE_FREE;
        end else begin
            used_words[id / bia_pkg::WORD_BITS][id % bia_pkg::WORD_BITS] = 1'b1;
            res.result_id = bia_pkg::ID_W'(id);
            res.status    = bia_pkg::ST_ALLOCATED;
        end
        return res;
    endfunction

    // Hold length: mostly short, now and then long
    function automatic int unsigned random_hold();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request driver: advance to the next request once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (pending_requests.size() != 0) begin
                i_in_data  <= pending_requests.pop_front();
                i_in_valid <= 1'b1;
                gap_left = (steady_in || $urandom_range(0, 1) == 0) ? 0 : random_hold();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result stall: random bursts of back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            if (!steady_out && $urandom_range(0, 99) < 30)
                stall_left = random_hold();
        end
    end

    // Monitor: predict on accepted requests, check accepted results, watch for hangs
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(apply_request(i_in_data));
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: id %0d status %0d", $time,
                             o_out_data.result_id, o_out_data.status);
                    mismatch_count++;
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (o_out_data.result_id !== oldest_result.result_id) begin
                        $display("%0t: result_id expected %0d actual %0d", $time,
                                 oldest_result.result_id, o_out_data.result_id);
                        mismatch_count++;
                    end
                    if (o_out_data.status !== oldest_result.status) begin
                        $display("%0t: status expected %s actual %0d", $time,
                                 oldest_result.status.name(), o_out_data.status);
                        mismatch_count++;
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_req(input bia_pkg::t_command cmd, input int unsigned id);
        bia_pkg::t_in_item req;
        req.command = cmd;
        req.free_id = bia_pkg::ID_W'(id);
        pending_requests.push_back(req);
    endtask

    // Wait until every request is taken and every result is back, then let the block settle
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_requests.size() != 0 || i_in_valid
                   || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the ID limit register through the APB port: setup, then access
    task automatic write_cap(input logic [bia_pkg::APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bia_pkg::REG_ID_LIMIT, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        cap_limit = 32'((value[bia_pkg::CAP_W-1:0] > bia_pkg::CAP_MAX)
                        ? bia_pkg::CAP_MAX : value[bia_pkg::CAP_W-1:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [bia_pkg::APB_DATA_W-1:0] cap,
                             input int unsigned count,
                             input int unsigned alloc_pct, input int unsigned id_hi);
        bia_pkg::t_in_item req;
        write_cap(cap);
        steady_in  = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            req.command = ($urandom_range(0, 99) < alloc_pct) ? bia_pkg::CMD_ALLOC
                                                               : bia_pkg::CMD_FREE;
            if ($urandom_range(0, 4) == 0)
                req.free_id = bia_pkg::ID_W'($urandom);
            else
                req.free_id = bia_pkg::ID_W'($urandom_range(0,
                                  (id_hi > bia_pkg::MAX_IDS - 1) ? bia_pkg::MAX_IDS - 1
                                                                 : id_hi));
            pending_requests.push_back(req);
        end
        wait_drained();
    endtask

    initial begin
        int unsigned rand_cap;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset capacity: lowest-first allocation, reuse, free of a free ID
        push_req(bia_pkg::CMD_ALLOC, 0);
        push_req(bia_pkg::CMD_ALLOC, 1023);
        push_req(bia_pkg::CMD_ALLOC, 0);
        push_req(bia_pkg::CMD_FREE, 1);
        push_req(bia_pkg::CMD_ALLOC, 0);
        push_req(bia_pkg::CMD_FREE, 1023);
        push_req(bia_pkg::CMD_FREE, 0);
        push_req(bia_pkg::CMD_ALLOC, 0);
        wait_drained();

        // Lowered capacity: none free, stale bit above the limit is out of range
        write_cap(32'd2);
        push_req(bia_pkg::CMD_ALLOC, 0);
        push_req(bia_pkg::CMD_FREE, 2);
        push_req(bia_pkg::CMD_FREE, 1023);
        wait_drained();

        // Raised by one: stale bit blocks allocation until freed
        write_cap(32'd3);
        push_req(bia_pkg::CMD_ALLOC, 0);
        push_req(bia_pkg::CMD_FREE, 2);
        push_req(bia_pkg::CMD_ALLOC, 0);
        wait_drained();

        // Zero capacity: nothing allocatable, every free out of range
        write_cap(32'd0);
        push_req(bia_pkg::CMD_ALLOC, 0);
        push_req(bia_pkg::CMD_FREE, 0);
        wait_drained();

        // Capacity beyond the table saturates
        write_cap(32'd2047);
        push_req(bia_pkg::CMD_FREE, 0);
        push_req(bia_pkg::CMD_FREE, 1);
        push_req(bia_pkg::CMD_FREE, 2);
        push_req(bia_pkg::CMD_ALLOC, 1023);
        push_req(bia_pkg::CMD_FREE, 1023);
        wait_drained();

        // Random phases over several capacities, the first one filling many words
        run_phase(32'd1024, 480, 92, 600);
        run_phase(32'd40, 70, 65, 47);
        run_phase(32'd0, 12, 50, 8);
        run_phase(32'hFFFF_F801, 20, 50, 3);
        run_phase(32'd2047, 60, 45, 1023);
        run_phase(32'd33, 50, 60, 40);
        run_phase(32'd1023, 40, 50, 1023);
        rand_cap = $urandom_range(1, 1100);
        run_phase(rand_cap, 70, 55, rand_cap + 8);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
